// File: rtl/core/nprc_pkg.sv
// ----------------------------------------------------------------------------
// nprc_pkg
// Shared types, constants and the distance function for the nearest palette
// color remapper.
// ----------------------------------------------------------------------------
package nprc_pkg;

    localparam int CH_W      = 8;
    localparam int COLOR_W   = 3 * CH_W;
    localparam int SLOT_W    = 4;
    localparam int DIST_W    = 18;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIST_W-1:0]  MAX_DIST      = DIST_W'(195075);
    localparam logic [COLOR_W-1:0] DEFAULT_RESET = 24'hFFFFFF;
    localparam logic [DIST_W-1:0]  TOL_RESET     = '0;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT   = 1'b1;

    typedef struct packed {
        logic               vld;
        logic               cmd;
        logic [SLOT_W-1:0]  slot;
        logic               slot_valid;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [COLOR_W-1:0] new_color;
        logic               found;
        logic [SLOT_W-1:0]  best_idx;
        logic [DIST_W-1:0]  best_dist;
        logic [COLOR_W-1:0] best_repl;
    } item_t;

    function automatic logic [2*CH_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] c,
                                                     input logic [CH_W-1:0] r,
                                                     input logic [CH_W-1:0] g,
                                                     input logic [CH_W-1:0] b);
        logic [DIST_W-1:0] dr;
        logic [DIST_W-1:0] dg;
        logic [DIST_W-1:0] db;
        dr = DIST_W'(sq_diff(c[3*CH_W-1:2*CH_W], r));
        dg = DIST_W'(sq_diff(c[2*CH_W-1:CH_W], g));
        db = DIST_W'(sq_diff(c[CH_W-1:0], b));
        return dr + dg + db;
    endfunction

endpackage

// File: rtl/core/nprc_cell.sv
// ----------------------------------------------------------------------------
// nprc_cell
// One palette slot of the chain: holds source color, replacement color and
// enable, loads them from a passing load item and updates the running best
// match of a passing pixel item.
// ----------------------------------------------------------------------------
module nprc_cell
    import nprc_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  item_t up,
    output item_t down
);

    localparam logic ADDRESSABLE = (CELL_IDX < (1 << SLOT_W));

    logic [COLOR_W-1:0] src_reg;
    logic [COLOR_W-1:0] src_next;
    logic [COLOR_W-1:0] repl_reg;
    logic [COLOR_W-1:0] repl_next;
    logic               en_reg;
    logic               en_next;
    item_t              down_reg;
    item_t              down_next;
    logic [DIST_W-1:0]  cand_dist;
    logic               load_hit;
    logic               closer;

    always_comb
    begin
        cand_dist = color_dist(src_reg, up.red, up.green, up.blue);
        load_hit  = up.vld && (up.cmd == CMD_LOAD) && ADDRESSABLE
                    && (up.slot == SLOT_W'(CELL_IDX));
        closer    = up.vld && (up.cmd == CMD_PIXEL) && en_reg
                    && (!up.found || (cand_dist < up.best_dist));

        src_next  = load_hit ? {up.red, up.green, up.blue} : src_reg;
        repl_next = load_hit ? up.new_color : repl_reg;
        en_next   = load_hit ? up.slot_valid : en_reg;

        down_next = up;
        if (closer)
        begin
            down_next.found     = 1'b1;
            down_next.best_idx  = SLOT_W'(CELL_IDX);
            down_next.best_dist = cand_dist;
            down_next.best_repl = repl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg       <= 1'b0;
            down_reg.vld <= 1'b0;
        end
        else if (advance)
        begin
            en_reg   <= en_next;
            down_reg <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            src_reg  <= src_next;
            repl_reg <= repl_next;
        end
    end

    assign down = down_reg;

    a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
        advance && up.vld && (up.cmd == CMD_PIXEL) && up.found |=> down.found)
        else $error("best match lost along the chain");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        down.vld && (down.cmd == CMD_PIXEL) && down.found |-> down.best_dist <= MAX_DIST)
        else $error("best distance out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(down_reg) && $stable(en_reg))
        else $error("cell changed while chain held");

endmodule

// File: rtl/core/nearest_palette_color_remap_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_remap_top
// Nearest palette color remapper: a chain of slot cells that each hold one
// palette entry; pixels walk the chain keeping the nearest enabled slot.
//
// Channel  Direction  Handshake              Payload
// item     in         item_valid/item_stall  cmd slot slot_valid red green
//                                            blue new_color
// result   out        result_valid/stall     out_color matched match_slot
// cfg      in         cfg_valid/cfg_ready    cfg_index cfg_data
//
// One item enters per cycle while the result channel is not stalled; a pixel
// result passes through the PALETTE_SLOTS cell registers in order and then
// loads the output register.
// Load items travel the same chain, so they act in order with pixels.
// Reset clears all slot enables at once; no clearing pass.
// A stalled result freezes the whole chain and stalls the item channel.
// ----------------------------------------------------------------------------
module nearest_palette_color_remap_top
    import nprc_pkg::*;
#(
    parameter int PALETTE_SLOTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 cmd,
    input  logic [SLOT_W-1:0]    slot,
    input  logic                 slot_valid,
    input  logic [CH_W-1:0]      red,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      blue,
    input  logic [COLOR_W-1:0]   new_color,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [COLOR_W-1:0]   out_color,
    output logic                 matched,
    output logic [SLOT_W-1:0]    match_slot,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    item_t              link [PALETTE_SLOTS+1];
    item_t              last;
    logic               advance;
    logic               hit;

    logic [DIST_W-1:0]  tol_reg;
    logic [DIST_W-1:0]  tol_next;
    logic [COLOR_W-1:0] dflt_reg;
    logic [COLOR_W-1:0] dflt_next;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic               matched_reg;
    logic               matched_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;

    assign advance    = !(res_valid_reg && result_stall);
    assign item_stall = !advance;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        link[0]            = '0;
        link[0].vld        = item_valid;
        link[0].cmd        = cmd;
        link[0].slot       = slot;
        link[0].slot_valid = slot_valid;
        link[0].red        = red;
        link[0].green      = green;
        link[0].blue       = blue;
        link[0].new_color  = new_color;
    end

    for (genvar i = 0; i < PALETTE_SLOTS; i++)
    begin : g_cell
        nprc_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .up      (link[i]),
            .down    (link[i+1])
        );
    end

    assign last = link[PALETTE_SLOTS];

    always_comb
    begin
        tol_next  = tol_reg;
        dflt_next = dflt_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TOLERANCE: tol_next  = cfg_data[DIST_W-1:0];
                REG_DEFAULT:   dflt_next = cfg_data;
            endcase
        end

        hit            = last.found && (last.best_dist < tol_reg);
        res_valid_next = last.vld && (last.cmd == CMD_PIXEL);
        color_next     = hit ? last.best_repl : dflt_reg;
        matched_next   = hit;
        slot_next      = last.best_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TOL_RESET;
            dflt_reg      <= DEFAULT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            tol_reg  <= tol_next;
            dflt_reg <= dflt_next;
            if (advance)
            begin
                res_valid_reg <= res_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            color_reg   <= color_next;
            matched_reg <= matched_next;
            slot_reg    <= slot_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_color    = color_reg;
    assign matched      = matched_reg;
    assign match_slot   = slot_reg;

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(last.vld && (last.cmd == CMD_PIXEL)))
        else $error("result without a pixel at the chain end");

    a_no_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last.vld && (last.cmd == CMD_LOAD) |=> !res_valid_reg)
        else $error("load item produced a result");

    a_match_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid_next && !last.found |=> !matched_reg && (slot_reg == '0))
        else $error("match reported with no enabled slot");

endmodule
